// ===== hw/rtl/lets_pkg.sv =====
// Shared types, widths and codes of the loop event trigger sequencer.
// Used by the controller, the datapath and the top level; depends on nothing.
package lets_pkg;

	localparam int MAX_NOTES  = 32;
	localparam int MAX_SOUNDS = 16;
	localparam int MAX_BLOCK  = 4096;

	localparam int BEAT_W    = 24;
	localparam int FRAC_W    = 8;
	localparam int FRAME_W   = 40;
	localparam int PROD_W    = 2 * BEAT_W;
	localparam int SOUND_W   = 4;
	localparam int SAMPLE_W  = 32;
	localparam int BLOCK_W   = 13;
	localparam int OFFSET_W  = 12;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 24;
	localparam int DIV_STEPS = FRAME_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_BEATS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FPB        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 2'd2;

	localparam logic [KIND_W-1:0] KIND_TRIGGER   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BLOCK_END = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOAD_OK   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LOAD_FULL = 2'd3;

	typedef struct packed {
		logic              capture;
		logic              mul;
		logic              idx_load_count;
		logic              idx_clear;
		logic              idx_dec;
		logic              idx_inc;
		logic              rd_prev;
		logic              rd_cur;
		logic              shift_wr;
		logic              ins_wr;
		logic              div_init;
		logic              div_step;
		logic              diff;
		logic              wrap;
		logic              emit;
		logic [KIND_W-1:0] emit_kind;
		logic              emit_silent;
		logic              emit_last;
	} lets_cmd_t;

	typedef struct packed {
		logic is_block;
		logic full;
		logic idx_zero;
		logic idx_end;
		logic silent_blk;
		logic prev_greater;
		logic hit;
		logic div_done;
		logic out_free;
	} lets_status_t;

endpackage

// ===== hw/rtl/loop_event_trigger_sequencer.sv =====
// Top level of the loop event trigger sequencer.
// Joins the controller and the datapath; depends on lets_pkg, lets_ctrl and lets_dp.
//
// A load transaction multiplies the start beat by frames-per-beat and inserts the
// note into the sorted table, walking down from the top and reading and comparing
// one entry at a time; on a full table it only reports the table full. A block
// transaction computes the loop length, then the loop position with a bit-serial
// remainder unit, then visits every stored note over the single table read port in
// read, difference, wrap and hit steps; a silent block skips both. A stalled output
// holds the transaction while a result waits. One transaction is in work at a time,
// and the result register lets the next transaction be taken while the final result
// still waits downstream.
module loop_event_trigger_sequencer #(
	parameter int MAX_NOTES = lets_pkg::MAX_NOTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lets_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lets_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic [lets_pkg::SOUND_W-1:0]    note_sound,
	input  logic [lets_pkg::BEAT_W-1:0]     note_start_beat,
	input  logic [lets_pkg::SAMPLE_W-1:0]   current_sample,
	input  logic                            playing,
	input  logic [lets_pkg::BLOCK_W-1:0]    block_frames,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lets_pkg::KIND_W-1:0]     kind,
	output logic [lets_pkg::SOUND_W-1:0]    trigger_sound,
	output logic [lets_pkg::OFFSET_W-1:0]   trigger_offset,
	output logic                            silent,
	output logic                            last
);

	lets_pkg::lets_cmd_t    cmd;
	lets_pkg::lets_status_t st;

	lets_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st(st),
		.cmd(cmd)
	);

	lets_dp #(
		.MAX_NOTES(MAX_NOTES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.action(action),
		.note_sound(note_sound),
		.note_start_beat(note_start_beat),
		.current_sample(current_sample),
		.playing(playing),
		.block_frames(block_frames),
		.cmd(cmd),
		.st(st),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.kind(kind),
		.trigger_sound(trigger_sound),
		.trigger_offset(trigger_offset),
		.silent(silent),
		.last(last)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Sequencer took a transaction without leaving idle.");

	a_accept_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> !(out_valid && !last))
		else $error("Transaction accepted before all results of the previous one.");

	a_silent_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && silent |-> (kind == lets_pkg::KIND_BLOCK_END) && last)
		else $error("Silent flag on a result that is not a final block end.");

	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == lets_pkg::KIND_LOAD_OK || kind == lets_pkg::KIND_LOAD_FULL)
		|-> last && !silent)
		else $error("Load result is not a single final result.");

endmodule

// ===== hw/rtl/lets_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Used for the note table; depends on nothing.
module lets_ram #(
	parameter int WIDTH = 44,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/lets_ctrl.sv =====
// Controller state machine of the loop event trigger sequencer.
// Drives datapath commands from datapath status; depends on lets_pkg.
module lets_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  lets_pkg::lets_status_t st,
	output lets_pkg::lets_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_MUL     = 4'd1;
	localparam logic [3:0] S_LD_CHK  = 4'd2;
	localparam logic [3:0] S_LD_RD   = 4'd3;
	localparam logic [3:0] S_LD_CMP  = 4'd4;
	localparam logic [3:0] S_LD_WR   = 4'd5;
	localparam logic [3:0] S_BLK_CHK = 4'd6;
	localparam logic [3:0] S_DIV     = 4'd7;
	localparam logic [3:0] S_NT_RD   = 4'd8;
	localparam logic [3:0] S_NT_DIFF = 4'd9;
	localparam logic [3:0] S_NT_WRAP = 4'd10;
	localparam logic [3:0] S_NT_HIT  = 4'd11;
	localparam logic [3:0] S_BLK_END = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_n;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_n = st.is_block ? S_BLK_CHK : S_LD_CHK;
			end
			S_LD_CHK: begin
				if (st.full) begin
					if (st.out_free) begin
						cmd.emit = 1'b1;
						cmd.emit_kind = lets_pkg::KIND_LOAD_FULL;
						cmd.emit_last = 1'b1;
						state_n = S_IDLE;
					end
				end else begin
					cmd.idx_load_count = 1'b1;
					state_n = S_LD_RD;
				end
			end
			S_LD_RD: begin
				if (st.idx_zero) begin
					state_n = S_LD_WR;
				end else begin
					cmd.rd_prev = 1'b1;
					state_n = S_LD_CMP;
				end
			end
			S_LD_CMP: begin
				if (st.prev_greater) begin
					cmd.shift_wr = 1'b1;
					cmd.idx_dec = 1'b1;
					state_n = S_LD_RD;
				end else begin
					state_n = S_LD_WR;
				end
			end
			S_LD_WR: begin
				if (st.out_free) begin
					cmd.ins_wr = 1'b1;
					cmd.emit = 1'b1;
					cmd.emit_kind = lets_pkg::KIND_LOAD_OK;
					cmd.emit_last = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_BLK_CHK: begin
				if (st.silent_blk) begin
					if (st.out_free) begin
						cmd.emit = 1'b1;
						cmd.emit_kind = lets_pkg::KIND_BLOCK_END;
						cmd.emit_silent = 1'b1;
						cmd.emit_last = 1'b1;
						state_n = S_IDLE;
					end
				end else begin
					cmd.div_init = 1'b1;
					state_n = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done) begin
					cmd.idx_clear = 1'b1;
					state_n = S_NT_RD;
				end
			end
			S_NT_RD: begin
				if (st.idx_end) begin
					state_n = S_BLK_END;
				end else begin
					cmd.rd_cur = 1'b1;
					state_n = S_NT_DIFF;
				end
			end
			S_NT_DIFF: begin
				cmd.diff = 1'b1;
				state_n = S_NT_WRAP;
			end
			S_NT_WRAP: begin
				cmd.wrap = 1'b1;
				state_n = S_NT_HIT;
			end
			S_NT_HIT: begin
				if (!st.hit) begin
					cmd.idx_inc = 1'b1;
					state_n = S_NT_RD;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = lets_pkg::KIND_TRIGGER;
					cmd.idx_inc = 1'b1;
					state_n = S_NT_RD;
				end
			end
			S_BLK_END: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = lets_pkg::KIND_BLOCK_END;
					cmd.emit_last = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

// ===== hw/rtl/lets_dp.sv =====
// Datapath of the loop event trigger sequencer: configuration, note table,
// multiplier, bit-serial remainder unit, offset logic and result register.
// Depends on lets_pkg and lets_ram.
module lets_dp #(
	parameter int MAX_NOTES = lets_pkg::MAX_NOTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lets_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lets_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            action,
	input  logic [lets_pkg::SOUND_W-1:0]    note_sound,
	input  logic [lets_pkg::BEAT_W-1:0]     note_start_beat,
	input  logic [lets_pkg::SAMPLE_W-1:0]   current_sample,
	input  logic                            playing,
	input  logic [lets_pkg::BLOCK_W-1:0]    block_frames,
	input  lets_pkg::lets_cmd_t             cmd,
	output lets_pkg::lets_status_t          st,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [lets_pkg::KIND_W-1:0]     kind,
	output logic [lets_pkg::SOUND_W-1:0]    trigger_sound,
	output logic [lets_pkg::OFFSET_W-1:0]   trigger_offset,
	output logic                            silent,
	output logic                            last
);

	localparam int CW = $clog2(MAX_NOTES + 1);
	localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int FW = lets_pkg::FRAME_W;
	localparam int SW = lets_pkg::SOUND_W;
	localparam int EW = FW + SW;
	localparam int BW = lets_pkg::BEAT_W;
	localparam int OW = FW - lets_pkg::FRAC_W + 1;
	localparam logic [OW-1:0] MaxBlk = OW'(lets_pkg::MAX_BLOCK);
	localparam logic [8:0] MaxSnd = 9'(lets_pkg::MAX_SOUNDS);
	localparam logic [FW:0] Half = (FW + 1)'(1 << (lets_pkg::FRAC_W - 1));

	logic [BW-1:0] loop_beats_q;
	logic [BW-1:0] fpb_q;
	logic          enabled_q;

	logic                           action_q;
	logic [SW-1:0]                  snd_q;
	logic [BW-1:0]                  beat_q;
	logic [lets_pkg::SAMPLE_W-1:0]  sample_q;
	logic                           playing_q;
	logic [lets_pkg::BLOCK_W-1:0]   block_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_m1;
	logic [FW-1:0] frame_q;
	logic [FW-1:0] rem_q;
	logic [FW-1:0] dvd_q;
	logic [lets_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [FW:0]   diff_q;
	logic [FW-1:0] sh_q;
	logic [SW-1:0] tsnd_q;

	logic [BW-1:0]                 mul_a;
	logic [lets_pkg::PROD_W-1:0]   prod;
	logic [FW:0]                   div_tmp;
	logic [FW+1:0]                 div_sub;
	logic [FW-1:0]                 rem_n;
	logic [FW:0]                   off_sum;
	logic [OW-1:0]                 off;
	logic [OW-1:0]                 blk_eff;

	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_wdata;
	logic [EW-1:0] ram_rdata;
	logic [FW-1:0] rd_frame;
	logic [SW-1:0] rd_sound;

	logic                           out_valid_q;
	logic [lets_pkg::KIND_W-1:0]    kind_q;
	logic [SW-1:0]                  tsound_q;
	logic [lets_pkg::OFFSET_W-1:0]  toffset_q;
	logic                           silent_q;
	logic                           last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_beats_q <= '0;
			fpb_q <= '0;
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				lets_pkg::CFG_LOOP_BEATS: loop_beats_q <= cfg_data;
				lets_pkg::CFG_FPB: fpb_q <= cfg_data;
				lets_pkg::CFG_ENABLED: enabled_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			snd_q <= note_sound;
			beat_q <= note_start_beat;
			sample_q <= current_sample;
			playing_q <= playing;
			block_q <= block_frames;
		end
	end

	assign mul_a = action_q ? loop_beats_q : beat_q;
	assign prod = {{BW{1'b0}}, mul_a} * {{BW{1'b0}}, fpb_q};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			frame_q <= prod[lets_pkg::PROD_W-1:lets_pkg::FRAC_W];
		end
	end

	assign div_tmp = {rem_q, dvd_q[FW-1]};
	assign div_sub = {1'b0, div_tmp} - {2'b00, frame_q};
	assign rem_n = div_sub[FW+1] ? div_tmp[FW-1:0] : div_sub[FW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			dvd_q <= {sample_q, {lets_pkg::FRAC_W{1'b0}}};
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_n;
			dvd_q <= {dvd_q[FW-2:0], 1'b0};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins_wr) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign idx_m1 = idx_q - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.idx_load_count) begin
			idx_q <= count_q;
		end else if (cmd.idx_clear) begin
			idx_q <= '0;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_m1;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign ram_we = cmd.shift_wr | cmd.ins_wr;
	assign ram_wdata = cmd.shift_wr ? ram_rdata : {snd_q, frame_q};
	assign ram_raddr = cmd.rd_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];

	lets_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_NOTES)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(idx_q[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_frame = ram_rdata[FW-1:0];
	assign rd_sound = ram_rdata[EW-1:FW];

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			diff_q <= {1'b0, rd_frame} - {1'b0, rem_q};
			tsnd_q <= rd_sound;
		end
		if (cmd.wrap) begin
			sh_q <= diff_q[FW] ? (diff_q[FW-1:0] + frame_q) : diff_q[FW-1:0];
		end
	end

	assign off_sum = {1'b0, sh_q} + Half;
	assign off = off_sum[FW:lets_pkg::FRAC_W];
	assign blk_eff = (OW'(block_q) > MaxBlk) ? MaxBlk : OW'(block_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= cmd.emit_kind;
			silent_q <= cmd.emit_silent;
			last_q <= cmd.emit_last;
			if (cmd.emit_kind == lets_pkg::KIND_TRIGGER) begin
				tsound_q <= tsnd_q;
				toffset_q <= off[lets_pkg::OFFSET_W-1:0];
			end else begin
				tsound_q <= '0;
				toffset_q <= '0;
			end
		end
	end

	assign st.is_block = action_q;
	assign st.full = (count_q == CW'(MAX_NOTES));
	assign st.idx_zero = (idx_q == '0);
	assign st.idx_end = (idx_q == count_q);
	assign st.silent_blk = !playing_q || !enabled_q || (frame_q == '0);
	assign st.prev_greater = (rd_frame > frame_q);
	assign st.hit = (off < blk_eff) && ({5'b0, tsnd_q} < MaxSnd);
	assign st.div_done = (div_cnt_q == lets_pkg::DIV_CNT_W'(lets_pkg::DIV_STEPS - 1));
	assign st.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign trigger_sound = tsound_q;
	assign trigger_offset = toffset_q;
	assign silent = silent_q;
	assign last = last_q;

endmodule

// ===== sim/loop_event_trigger_sequencer_tb.sv =====
// Self-checking testbench of the loop event trigger sequencer.
// Needs lets_pkg and the loop_event_trigger_sequencer RTL; a table of directed cases
// precedes random note loads and audio blocks, checked by a predictor or a set result.
`timescale 1ns / 100ps

module loop_event_trigger_sequencer_tb;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_BLOCK = 1'b1;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int TAIL_CYCLES = 200;

	typedef enum logic {ROW_WRITE, ROW_XFER} row_op_t;

	typedef struct {
		logic                          act;
		logic [lets_pkg::SOUND_W-1:0]  snd;
		logic [lets_pkg::BEAT_W-1:0]   beat;
		logic [lets_pkg::SAMPLE_W-1:0] sample_pos;
		logic                          play;
		logic [lets_pkg::BLOCK_W-1:0]  frames;
	} seq_item_t;

	typedef struct packed {
		logic [lets_pkg::KIND_W-1:0]   kind;
		logic [lets_pkg::SOUND_W-1:0]  snd;
		logic [lets_pkg::OFFSET_W-1:0] offset;
		logic                          silent;
		logic                          last;
	} trig_result_t;

	typedef struct {
		row_op_t                        op;
		logic [lets_pkg::CFG_IDX_W-1:0] cfg_idx;
		logic [lets_pkg::CFG_W-1:0]     cfg_val;
		seq_item_t                      item;
		bit                             typed;
		logic                           exp_silent;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [lets_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lets_pkg::CFG_W-1:0]      cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic                            action = 1'b0;
	logic [lets_pkg::SOUND_W-1:0]    note_sound = '0;
	logic [lets_pkg::BEAT_W-1:0]     note_start_beat = '0;
	logic [lets_pkg::SAMPLE_W-1:0]   current_sample = '0;
	logic                            playing = 1'b0;
	logic [lets_pkg::BLOCK_W-1:0]    block_frames = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [lets_pkg::KIND_W-1:0]     kind;
	logic [lets_pkg::SOUND_W-1:0]    trigger_sound;
	logic [lets_pkg::OFFSET_W-1:0]   trigger_offset;
	logic                            silent;
	logic                            last;

	loop_event_trigger_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .note_sound(note_sound), .note_start_beat(note_start_beat),
		.current_sample(current_sample), .playing(playing), .block_frames(block_frames),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .trigger_sound(trigger_sound), .trigger_offset(trigger_offset),
		.silent(silent), .last(last)
	);

	logic [lets_pkg::FRAME_W-1:0] note_frames [lets_pkg::MAX_NOTES];
	logic [lets_pkg::SOUND_W-1:0] note_sounds [lets_pkg::MAX_NOTES];
	int unsigned                  note_total = 0;
	logic [lets_pkg::BEAT_W-1:0]  loop_beats_cfg = '0;
	logic [lets_pkg::BEAT_W-1:0]  beat_frames_cfg = '0;
	logic                         enable_cfg = 1'b0;

	trig_result_t due_results[$];
	dir_row_t     directed[$];
	bit           idling = 1'b1;
	int unsigned  cycle_count = 0;
	int unsigned  stall_run = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  results_checked = 0;
	int unsigned  triggers_seen = 0;
	int unsigned  loads_refused = 0;
	int unsigned  loads_sent = 0;
	int unsigned  blocks_sent = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic trig_result_t make_result(logic [lets_pkg::KIND_W-1:0] k,
			logic [lets_pkg::SOUND_W-1:0] s, logic [lets_pkg::OFFSET_W-1:0] o,
			logic sil, logic lst);
		return {k, s, o, sil, lst};
	endfunction

	function automatic logic [lets_pkg::FRAME_W-1:0] beats_to_frame_val(
			logic [lets_pkg::BEAT_W-1:0] beats);
		logic [lets_pkg::PROD_W-1:0] prod;
		prod = {{lets_pkg::BEAT_W{1'b0}}, beats} * {{lets_pkg::BEAT_W{1'b0}}, beat_frames_cfg};
		return prod[lets_pkg::PROD_W-1:lets_pkg::FRAC_W];
	endfunction

	function automatic void sequencer_outputs(input seq_item_t it, output trig_result_t res[$]);
		logic [lets_pkg::FRAME_W-1:0] frame;
		logic [lets_pkg::FRAME_W-1:0] loop_len;
		logic [63:0]                  loop_pos;
		logic [63:0]                  shifted;
		logic [63:0]                  offset;
		logic [63:0]                  span;
		int                           pos;
		res = {};
		if (it.act == ACT_LOAD) begin
			if (note_total >= lets_pkg::MAX_NOTES) begin
				res = {res, make_result(lets_pkg::KIND_LOAD_FULL, '0, '0, 1'b0, 1'b1)};
				return;
			end
			frame = beats_to_frame_val(it.beat);
			pos = int'(note_total);
			while (pos > 0 && note_frames[pos-1] > frame) begin
				note_frames[pos] = note_frames[pos-1];
				note_sounds[pos] = note_sounds[pos-1];
				pos--;
			end
			note_frames[pos] = frame;
			note_sounds[pos] = it.snd;
			note_total++;
			res = {res, make_result(lets_pkg::KIND_LOAD_OK, '0, '0, 1'b0, 1'b1)};
			return;
		end
		loop_len = beats_to_frame_val(loop_beats_cfg);
		if (!it.play || !enable_cfg || loop_len == '0) begin
			res = {res, make_result(lets_pkg::KIND_BLOCK_END, '0, '0, 1'b1, 1'b1)};
			return;
		end
		span = 64'(it.frames);
		if (span > 64'(lets_pkg::MAX_BLOCK))
			span = 64'(lets_pkg::MAX_BLOCK);
		loop_pos = {24'd0, it.sample_pos, 8'd0} % 64'(loop_len);
		for (int i = 0; i < note_total; i++) begin
			if (64'(note_frames[i]) >= loop_pos)
				shifted = 64'(note_frames[i]) - loop_pos;
			else
				shifted = 64'(note_frames[i]) + 64'(loop_len) - loop_pos;
			offset = (shifted + 64'd128) >> lets_pkg::FRAC_W;
			if (offset < span && note_sounds[i] < lets_pkg::MAX_SOUNDS)
				res = {res, make_result(lets_pkg::KIND_TRIGGER, note_sounds[i],
					offset[lets_pkg::OFFSET_W-1:0], 1'b0, 1'b0)};
		end
		res = {res, make_result(lets_pkg::KIND_BLOCK_END, '0, '0, 1'b0, 1'b1)};
	endfunction

	function automatic dir_row_t reg_row(logic [lets_pkg::CFG_IDX_W-1:0] idx,
			logic [lets_pkg::CFG_W-1:0] val);
		dir_row_t row;
		row.op = ROW_WRITE;
		row.cfg_idx = idx;
		row.cfg_val = val;
		row.item = '{ACT_LOAD, '0, '0, '0, 1'b0, '0};
		row.typed = 1'b0;
		row.exp_silent = 1'b0;
		return row;
	endfunction

	function automatic dir_row_t load_row(logic [lets_pkg::SOUND_W-1:0] snd,
			logic [lets_pkg::BEAT_W-1:0] beat);
		dir_row_t row;
		row = reg_row(lets_pkg::CFG_LOOP_BEATS, '0);
		row.op = ROW_XFER;
		row.item = '{ACT_LOAD, snd, beat, $urandom, 1'($urandom), 13'($urandom)};
		row.typed = 1'b1;
		return row;
	endfunction

	function automatic dir_row_t block_row(logic [lets_pkg::SAMPLE_W-1:0] sample_pos,
			logic play, logic [lets_pkg::BLOCK_W-1:0] frames, bit typed, logic exp_silent);
		dir_row_t row;
		row = reg_row(lets_pkg::CFG_LOOP_BEATS, '0);
		row.op = ROW_XFER;
		row.item = '{ACT_BLOCK, 4'($urandom), 24'($urandom), sample_pos, play, frames};
		row.typed = typed;
		row.exp_silent = exp_silent;
		return row;
	endfunction

	function automatic seq_item_t random_item();
		seq_item_t it;
		it.act = ($urandom_range(0, 99) < 15) ? ACT_LOAD : ACT_BLOCK;
		it.snd = 4'($urandom);
		if ($urandom_range(0, 7) == 0)
			it.beat = 24'($urandom);
		else
			it.beat = 24'($urandom_range(0, loop_beats_cfg));
		it.sample_pos = $urandom;
		it.play = ($urandom_range(0, 15) != 0);
		case ($urandom_range(0, 9))
			0: it.frames = 13'($urandom_range(0, 8191));
			1: it.frames = 13'(lets_pkg::MAX_BLOCK);
			default: it.frames = 13'($urandom_range(1, 512));
		endcase
		return it;
	endfunction

	task automatic write_reg(logic [lets_pkg::CFG_IDX_W-1:0] idx,
			logic [lets_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			lets_pkg::CFG_LOOP_BEATS: loop_beats_cfg = val;
			lets_pkg::CFG_FPB: beat_frames_cfg = val;
			lets_pkg::CFG_ENABLED: enable_cfg = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_item(seq_item_t it, bit typed, logic exp_silent);
		trig_result_t res[$];
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.act;
		note_sound <= it.snd;
		note_start_beat <= it.beat;
		current_sample <= it.sample_pos;
		playing <= it.play;
		block_frames <= it.frames;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sequencer_outputs(it, res);
		if (typed) begin
			res = {make_result((it.act == ACT_LOAD) ? lets_pkg::KIND_LOAD_OK
				: lets_pkg::KIND_BLOCK_END, '0, '0, exp_silent, 1'b1)};
		end
		due_results = {due_results, res};
		if (it.act == ACT_LOAD)
			loads_sent++;
		else
			blocks_sent++;
	endtask

	function automatic void note_mismatch(string what, trig_result_t want, trig_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s at cycle %0d: expected kind=%0d sound=%0d offset=%0d silent=%0b last=%0b",
				what, cycle_count, want.kind, want.snd, want.offset, want.silent, want.last);
			$display("    got kind=%0d sound=%0d offset=%0d silent=%0b last=%0b",
				got.kind, got.snd, got.offset, got.silent, got.last);
		end
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, due_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_run != 0) begin
			stall_run--;
		end else begin
			stall_run = $urandom_range(1, 16);
			out_stall <= idling && ($urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		trig_result_t got;
		trig_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, trigger_sound, trigger_offset, silent, last};
			results_checked++;
			if (got.kind == lets_pkg::KIND_TRIGGER)
				triggers_seen++;
			if (got.kind == lets_pkg::KIND_LOAD_FULL)
				loads_refused++;
			if (due_results.size() == 0) begin
				note_mismatch("Unexpected transaction", '0, got);
			end else begin
				want = due_results.pop_front();
				if (got.kind !== want.kind || got.snd !== want.snd
						|| got.offset !== want.offset || got.silent !== want.silent
						|| got.last !== want.last)
					note_mismatch("Mismatch", want, got);
			end
		end
	end

	initial begin
		directed = '{
			block_row(32'h0, 1'b1, 13'd16, 1'b1, 1'b1),
			load_row(4'd9, 24'h000100),
			reg_row(lets_pkg::CFG_LOOP_BEATS, 24'h001000),
			reg_row(lets_pkg::CFG_FPB, 24'h006400),
			reg_row(lets_pkg::CFG_ENABLED, 24'h000001),
			load_row(4'd15, 24'h000000),
			load_row(4'd0, 24'hFFFFFF),
			load_row(4'd3, 24'h000400),
			load_row(4'd5, 24'h000400),
			load_row(4'd10, 24'h000280),
			load_row(4'd12, 24'h000FFF),
			block_row(32'h0, 1'b0, 13'd4096, 1'b1, 1'b1),
			block_row(32'h0, 1'b1, 13'd4096, 1'b0, 1'b0),
			block_row(32'hFFFFFFFF, 1'b1, 13'd1, 1'b0, 1'b0),
			block_row(32'd1500, 1'b1, 13'd200, 1'b0, 1'b0),
			block_row(32'd0, 1'b1, 13'd0, 1'b1, 1'b0),
			block_row(32'd800, 1'b1, 13'h1FFF, 1'b0, 1'b0),
			block_row(32'd1599, 1'b1, 13'd2, 1'b0, 1'b0),
			reg_row(lets_pkg::CFG_FPB, 24'h0080A1),
			load_row(4'd7, 24'h000381),
			block_row(32'h12345678, 1'b1, 13'd4096, 1'b0, 1'b0),
			reg_row(lets_pkg::CFG_ENABLED, 24'h000000),
			block_row(32'd0, 1'b1, 13'd64, 1'b1, 1'b1),
			reg_row(lets_pkg::CFG_ENABLED, 24'h000001),
			reg_row(lets_pkg::CFG_LOOP_BEATS, 24'hFFFFFF),
			reg_row(lets_pkg::CFG_FPB, 24'hFFFFFF),
			block_row(32'hFFFFFFFF, 1'b1, 13'd4096, 1'b0, 1'b0),
			load_row(4'd1, 24'hFFFFFF),
			block_row(32'h0, 1'b1, 13'd4096, 1'b0, 1'b0),
			reg_row(lets_pkg::CFG_LOOP_BEATS, 24'h000000),
			block_row(32'd100, 1'b1, 13'd4096, 1'b1, 1'b1),
			reg_row(lets_pkg::CFG_FPB, 24'h000000),
			reg_row(lets_pkg::CFG_LOOP_BEATS, 24'h001000),
			block_row(32'd100, 1'b1, 13'd4096, 1'b1, 1'b1)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r]) begin
			if (directed[r].op == ROW_WRITE) begin
				drain_results();
				write_reg(directed[r].cfg_idx, directed[r].cfg_val);
			end else begin
				send_item(directed[r].item, directed[r].typed, directed[r].exp_silent);
			end
		end

		for (int phase = 0; phase < 6; phase++) begin
			drain_results();
			if (phase == 5)
				idling = 1'b0;
			if (phase == 2) begin
				write_reg(lets_pkg::CFG_LOOP_BEATS, 24'h000001);
				write_reg(lets_pkg::CFG_FPB, 24'hFFFFFF);
			end else begin
				write_reg(lets_pkg::CFG_LOOP_BEATS,
					24'($urandom_range(24'h000100, 24'h002000)));
				write_reg(lets_pkg::CFG_FPB, 24'($urandom_range(24'h001000, 24'h00C000)));
			end
			write_reg(lets_pkg::CFG_ENABLED, (phase == 3) ? 24'd0 : 24'd1);
			repeat ((phase == 3) ? 20 : 80)
				send_item(random_item(), 1'b0, 1'b0);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d note loads (%0d refused on a full table) and %0d audio blocks",
			loads_sent, loads_refused, blocks_sent);
		$display("Checked %0d results including %0d triggers; %0d mismatches in %0d cycles",
			results_checked, triggers_seen, mismatch_count, cycle_count);
		if (mismatch_count == 0 && due_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
